@@ rtl/mctd_pkg.sv @@
`default_nettype none
package mctd_pkg;

	localparam int VlanEntries = 4096;
	localparam int VidBits     = 12;
	localparam logic [7:0] DIGEST_STEPS = 8'd132;

	// action codes
	localparam logic [2:0] ACT_SET    = 3'd0;
	localparam logic [2:0] ACT_CLEAR  = 3'd1;
	localparam logic [2:0] ACT_LOOKUP = 3'd2;
	localparam logic [2:0] ACT_STEP   = 3'd3;
	localparam logic [2:0] ACT_FINISH = 3'd4;

	// step numbers with special message blocks
	localparam logic [7:0] STEP_IPAD  = 8'd0;
	localparam logic [7:0] STEP_IFIN  = 8'd129;
	localparam logic [7:0] STEP_OPAD  = 8'd130;
	localparam logic [7:0] STEP_OFIN  = 8'd131;

	typedef logic [3:0][31:0] quad_t;

	localparam quad_t INIT_WORDS = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};
	localparam quad_t KEY_WORDS  = {32'h4603cd43, 32'ha22b5df9, 32'h51fd472e, 32'ha606ac13};
	localparam quad_t EMPTY_DIGEST = {32'h62de26ab, 32'hd82138b8, 32'hd43c2850, 32'h7f1736ac};
	localparam logic [31:0] IPAD_WORD = 32'h36363636;
	localparam logic [31:0] OPAD_WORD = 32'h5c5c5c5c;
	localparam logic [31:0] PAD_BIT   = 32'h00000080;
	localparam logic [31:0] ILEN_WORD = 32'h00010200;
	localparam logic [31:0] OLEN_WORD = 32'h00000280;

	// control from the sequencer to the round unit
	typedef struct packed {
		logic        chain_init;
		logic        run;
		logic        msg_we;
		logic        msg_merge;
		logic [3:0]  msg_idx;
		logic [31:0] msg_data;
	} md5_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} md5_sts_t;

	function automatic logic [31:0] sine_k(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
			6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
			6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
			6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
			6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
			6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
			6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
			6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
			6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
			6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
			6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
			6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
			default: k = 32'heb86d391;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] rot_amt(input logic [5:0] i);
		logic [4:0] s;
		case ({i[5:4], i[1:0]})
			4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
			4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
			4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15;
			default: s = 5'd21;
		endcase
		return s;
	endfunction

	function automatic logic [3:0] msg_sel(input logic [5:0] i);
		logic [3:0] g;
		case (i[5:4])
			2'd0: g = i[3:0];
			2'd1: g = 4'(i[3:0] * 4'd5 + 4'd1);
			2'd2: g = 4'(i[3:0] * 4'd3 + 4'd5);
			default: g = 4'(i[3:0] * 4'd7);
		endcase
		return g;
	endfunction

endpackage
`default_nettype wire

@@ rtl/mctd_md5.sv @@
`default_nettype none
module mctd_md5
	import mctd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire md5_ctl_t ctl,
	output md5_sts_t      sts,
	output quad_t         chain
);

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_A    = 4'b0010,
		PH_B    = 4'b0100,
		PH_FOLD = 4'b1000
	} phase_t;

	phase_t      phase_q;
	logic [5:0]  rnd_q;
	logic        done_q;
	logic [31:0] a_q, b_q, c_q, d_q, tmp_q;
	logic [31:0] msg_q [16];
	quad_t       chain_q;

	logic [31:0] f_val, sum_b;
	logic [63:0] rot_w;
	logic [4:0]  s_amt;

	// round function for the current quarter
	always_comb begin
		case (rnd_q[5:4])
			2'd0: f_val = (b_q & c_q) | (~b_q & d_q);
			2'd1: f_val = (d_q & b_q) | (~d_q & c_q);
			2'd2: f_val = b_q ^ c_q ^ d_q;
			default: f_val = c_q ^ (b_q | ~d_q);
		endcase
		s_amt = rot_amt(rnd_q);
		sum_b = f_val + tmp_q;
		rot_w = {sum_b, sum_b} << s_amt;
	end

	// message block words
	always_ff @(posedge clk) begin
		if (ctl.msg_we) begin
			msg_q[ctl.msg_idx] <= ctl.msg_merge ? (msg_q[ctl.msg_idx] | ctl.msg_data)
				: ctl.msg_data;
		end
	end

	// working words and chaining value
	always_ff @(posedge clk) begin
		if (ctl.chain_init) begin
			chain_q <= INIT_WORDS;
		end else if (phase_q == PH_FOLD) begin
			chain_q[0] <= chain_q[0] + a_q;
			chain_q[1] <= chain_q[1] + b_q;
			chain_q[2] <= chain_q[2] + c_q;
			chain_q[3] <= chain_q[3] + d_q;
		end
		if (ctl.run) begin
			a_q <= ctl.chain_init ? INIT_WORDS[0] : chain_q[0];
			b_q <= ctl.chain_init ? INIT_WORDS[1] : chain_q[1];
			c_q <= ctl.chain_init ? INIT_WORDS[2] : chain_q[2];
			d_q <= ctl.chain_init ? INIT_WORDS[3] : chain_q[3];
		end else if (phase_q == PH_A) begin
			tmp_q <= a_q + sine_k(rnd_q) + msg_q[msg_sel(rnd_q)];
		end else if (phase_q == PH_B) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= b_q + rot_w[63:32];
		end
	end

	// round sequencer: phases A and B for each round, then a fold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			rnd_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				PH_IDLE: begin
					if (ctl.run) begin
						phase_q <= PH_A;
						rnd_q   <= '0;
					end
				end
				PH_A: phase_q <= PH_B;
				PH_B: begin
					rnd_q   <= rnd_q + 6'd1;
					phase_q <= (rnd_q == 6'd63) ? PH_FOLD : PH_A;
				end
				PH_FOLD: begin
					phase_q <= PH_IDLE;
					done_q  <= 1'b1;
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	assign sts.busy = (phase_q != PH_IDLE);
	assign sts.done = done_q;
	assign chain    = chain_q;

`ifndef SYNTHESIS
	a_done_after_fold: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(phase_q == PH_FOLD)) else $error("done without fold");
	a_run_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.run |-> phase_q == PH_IDLE) else $error("run while busy");
	a_round_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FOLD |-> rnd_q == 6'd0) else $error("fold before last round");
`endif

endmodule
`default_nettype wire

@@ rtl/mst_config_table_digest.sv @@
`default_nettype none
// MST configuration table with HMAC-MD5 configuration digest. After reset the
// block runs a clearing pass over the whole VLAN table and stalls requests
// until it ends. One beat is taken at a time: a range set or an instance clear
// walks the table one VLAN at a time, reading each entry and writing it back if
// it changes (first to last, or 1 to MAX_VID), a lookup reads one table entry,
// and one digest step loads a message block (table blocks through the single
// table read port) and then runs the shared round unit for 64 rounds plus a
// fold. A finish runs every remaining step and returns four result beats.
module mst_config_table_digest
	import mctd_pkg::*;
#(
	parameter int MAX_VID = 4095
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [2:0]  action,
	input  wire logic [11:0] first_vid,
	input  wire logic [11:0] last_vid,
	input  wire logic [3:0]  instance_req,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic [3:0]       vid_instance,
	output logic [15:0]      used_instances,
	output logic [31:0]      digest_word,
	output logic [1:0]       word_index,
	output logic             digest_pending,
	output logic             last
);

	localparam logic [12:0] MaxVid = 13'(MAX_VID);

	typedef enum logic [8:0] {
		ST_CLR    = 9'b000000001,
		ST_IDLE   = 9'b000000010,
		ST_WRD    = 9'b000000100,
		ST_WWR    = 9'b000001000,
		ST_LOOK   = 9'b000010000,
		ST_DSTART = 9'b000100000,
		ST_DLOAD  = 9'b001000000,
		ST_DRUN   = 9'b010000000,
		ST_EMIT   = 9'b100000000
	} state_t;

	state_t      state_q;
	logic [2:0]  act_q;
	logic [12:0] vid_q, end_q;
	logic [3:0]  inst_q, found_q;
	logic [7:0]  step_q;
	logic [5:0]  ld_q;
	logic [11:0] clr_q;
	logic [1:0]  emit_q;
	quad_t       dig_q, inner_q;
	logic [12:0] cnt_q [16];

	logic [3:0]  tbl_mem [VlanEntries];
	logic [3:0]  tbl_rd_q;
	logic [11:0] rd_addr, wr_addr;
	logic [3:0]  wr_data;
	logic        tbl_we;

	logic        rsp_valid_q, rsp_load;
	logic [3:0]  rsp_inst_q;
	logic [15:0] rsp_used_q;
	logic [31:0] rsp_word_q;
	logic [1:0]  rsp_idx_q;
	logic        rsp_pend_q, rsp_last_q;

	md5_ctl_t    md5_ctl;
	md5_sts_t    md5_sts;
	quad_t       chain;

	logic [3:0]  new_inst;
	logic        walk_chg, tbl_blk, ld_end;
	logic [5:0]  ld_m1;
	logic [31:0] const_word;
	logic [15:0] used_w;
	logic        req_fire;

	assign req_fire = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);

	// used mask follows the nonzero counts, instance 0 never counted
	always_comb begin
		used_w = '0;
		for (int n = 1; n < 16; n++) begin
			used_w[n] = (cnt_q[n] != '0);
		end
	end

	// walk write decision
	assign new_inst = (act_q == ACT_SET) ? inst_q : 4'd0;
	assign walk_chg = (tbl_rd_q != new_inst) && ((act_q == ACT_SET) || (tbl_rd_q == inst_q));

	// message block source for the current step
	assign tbl_blk = (step_q != STEP_IPAD) && (step_q <= 8'd128);
	assign ld_m1   = ld_q - 6'd1;
	assign ld_end  = tbl_blk ? (ld_q == 6'd32) : (ld_q == 6'd15);

	always_comb begin
		const_word = '0;
		if (step_q == STEP_IPAD || step_q == STEP_OPAD) begin
			const_word = (step_q == STEP_IPAD) ? IPAD_WORD : OPAD_WORD;
			if (ld_q[3:2] == 2'd0) begin
				const_word = const_word ^ KEY_WORDS[ld_q[1:0]];
			end
		end else if (step_q == STEP_IFIN) begin
			if (ld_q[3:0] == 4'd0) begin
				const_word = PAD_BIT;
			end else if (ld_q[3:0] == 4'd14) begin
				const_word = ILEN_WORD;
			end
		end else begin
			if (ld_q[3:2] == 2'd0) begin
				const_word = inner_q[ld_q[1:0]];
			end else if (ld_q[3:0] == 4'd4) begin
				const_word = PAD_BIT;
			end else if (ld_q[3:0] == 4'd14) begin
				const_word = OLEN_WORD;
			end
		end
	end

	// round unit control
	always_comb begin
		md5_ctl = '0;
		md5_ctl.chain_init = (state_q == ST_DSTART)
			&& (step_q == STEP_IPAD || step_q == STEP_OPAD);
		md5_ctl.run = (state_q == ST_DLOAD) && ld_end;
		if (state_q == ST_DLOAD) begin
			if (tbl_blk) begin
				md5_ctl.msg_we    = (ld_q != 6'd0);
				md5_ctl.msg_idx   = ld_m1[4:1];
				md5_ctl.msg_merge = ld_m1[0];
				md5_ctl.msg_data  = ld_m1[0] ? {4'd0, tbl_rd_q, 24'd0}
					: {20'd0, tbl_rd_q, 8'd0};
			end else begin
				md5_ctl.msg_we   = 1'b1;
				md5_ctl.msg_idx  = ld_q[3:0];
				md5_ctl.msg_data = const_word;
			end
		end
	end

	mctd_md5 u_md5 (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (md5_ctl),
		.sts    (md5_sts),
		.chain  (chain)
	);

	// table port selection
	always_comb begin
		if (state_q == ST_IDLE) begin
			rd_addr = first_vid;
		end else if (state_q == ST_DLOAD) begin
			rd_addr = {7'(step_q - 8'd1), ld_q[4:0]};
		end else begin
			rd_addr = vid_q[11:0];
		end
		if (state_q == ST_CLR) begin
			tbl_we  = 1'b1;
			wr_addr = clr_q;
			wr_data = 4'd0;
		end else begin
			tbl_we  = (state_q == ST_WWR) && walk_chg;
			wr_addr = vid_q[11:0];
			wr_data = new_inst;
		end
	end

	// vlan table memory
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[wr_addr] <= wr_data;
		end
		tbl_rd_q <= tbl_mem[rd_addr];
	end

	assign rsp_load = (state_q == ST_EMIT) && (!rsp_valid_q || !rsp_stall);

	// per-instance vlan counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < 16; n++) begin
				cnt_q[n] <= '0;
			end
		end else if (state_q == ST_WWR && walk_chg) begin
			for (int n = 1; n < 16; n++) begin
				if (tbl_rd_q == 4'(n)) begin
					cnt_q[n] <= cnt_q[n] - 13'd1;
				end else if (new_inst == 4'(n)) begin
					cnt_q[n] <= cnt_q[n] + 13'd1;
				end
			end
		end
	end

	// digest words and inner hash
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_q <= EMPTY_DIGEST;
		end else if (state_q == ST_DRUN && md5_sts.done && step_q == STEP_OFIN) begin
			dig_q <= chain;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DRUN && md5_sts.done && step_q == STEP_IFIN) begin
			inner_q <= chain;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			step_q  <= DIGEST_STEPS;
			act_q   <= ACT_SET;
			vid_q   <= '0;
			end_q   <= '0;
			inst_q  <= '0;
			found_q <= '0;
			ld_q    <= '0;
			emit_q  <= '0;
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 12'd1;
					if (clr_q == 12'hfff) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						act_q   <= action;
						inst_q  <= instance_req;
						found_q <= '0;
						emit_q  <= '0;
						case (action)
							ACT_SET: begin
								vid_q <= {1'b0, first_vid};
								end_q <= {1'b0, last_vid};
								if (last_vid < first_vid) begin
									step_q  <= '0;
									state_q <= ST_EMIT;
								end else begin
									state_q <= ST_WRD;
								end
							end
							ACT_CLEAR: begin
								vid_q   <= 13'd1;
								end_q   <= MaxVid;
								state_q <= ST_WRD;
							end
							ACT_LOOKUP: state_q <= ST_LOOK;
							ACT_STEP, ACT_FINISH: begin
								state_q <= (step_q < DIGEST_STEPS) ? ST_DSTART : ST_EMIT;
							end
							default: state_q <= ST_EMIT;
						endcase
					end
				end
				ST_WRD: state_q <= ST_WWR;
				ST_WWR: begin
					vid_q <= vid_q + 13'd1;
					if (vid_q == end_q) begin
						step_q  <= '0;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_WRD;
					end
				end
				ST_LOOK: begin
					found_q <= tbl_rd_q;
					state_q <= ST_EMIT;
				end
				ST_DSTART: begin
					ld_q    <= '0;
					state_q <= ST_DLOAD;
				end
				ST_DLOAD: begin
					ld_q <= ld_q + 6'd1;
					if (ld_end) begin
						state_q <= ST_DRUN;
					end
				end
				ST_DRUN: begin
					if (md5_sts.done) begin
						step_q <= step_q + 8'd1;
						if (act_q == ACT_FINISH && step_q != STEP_OFIN) begin
							state_q <= ST_DSTART;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (rsp_load) begin
						emit_q <= emit_q + 2'd1;
						if (act_q != ACT_FINISH || emit_q == 2'd3) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_inst_q <= found_q;
			rsp_used_q <= used_w;
			rsp_word_q <= (act_q == ACT_FINISH) ? dig_q[emit_q] : 32'd0;
			rsp_idx_q  <= (act_q == ACT_FINISH) ? emit_q : 2'd0;
			rsp_pend_q <= (step_q < DIGEST_STEPS);
			rsp_last_q <= (act_q != ACT_FINISH) || (emit_q == 2'd3);
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign vid_instance   = rsp_inst_q;
	assign used_instances = rsp_used_q;
	assign digest_word    = rsp_word_q;
	assign word_index     = rsp_idx_q;
	assign digest_pending = rsp_pend_q;
	assign last           = rsp_last_q;

`ifndef SYNTHESIS
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= DIGEST_STEPS) else $error("step count out of range");
	a_cist_unused: assert property (@(posedge clk) disable iff (!arst_n)
		used_w[0] == 1'b0) else $error("instance 0 marked used");
	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		md5_sts.done |-> state_q == ST_DRUN) else $error("round unit done out of run");
	a_finish_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load && act_q == ACT_FINISH |-> step_q == DIGEST_STEPS)
		else $error("digest emitted while steps pending");
`endif

endmodule
`default_nettype wire
